// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the two-wire bus sequencer.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/i2c_seq_pkg.sv -----
// Shared types and constants of the two-wire bus sequencer.
// No dependencies; imported by the controller, the datapath and the top level.
package i2c_seq_pkg;

   // buffer geometry
   localparam int BUF_DEPTH = 16;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);
   localparam int CNT_W     = 5;

   // request functions
   localparam logic [1:0] FUNC_EVENT = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_SEND  = 2'd2;
   localparam logic [1:0] FUNC_FETCH = 2'd3;

   // bus commands
   localparam logic [1:0] CMD_RELEASE = 2'd0;
   localparam logic [1:0] CMD_START   = 2'd1;
   localparam logic [1:0] CMD_STOP    = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   // interface status codes (low three bits masked)
   localparam logic [7:0] SC_MASK            = 8'hf8;
   localparam logic [7:0] SC_START           = 8'h08;
   localparam logic [7:0] SC_REP_START       = 8'h10;
   localparam logic [7:0] SC_MT_SLA_ACK      = 8'h18;
   localparam logic [7:0] SC_MT_SLA_NACK     = 8'h20;
   localparam logic [7:0] SC_MT_DATA_ACK     = 8'h28;
   localparam logic [7:0] SC_MT_DATA_NACK    = 8'h30;
   localparam logic [7:0] SC_ARB_LOST        = 8'h38;
   localparam logic [7:0] SC_SR_SLA_ACK      = 8'h60;
   localparam logic [7:0] SC_SR_ARB_SLA      = 8'h68;
   localparam logic [7:0] SC_SR_GCALL        = 8'h70;
   localparam logic [7:0] SC_SR_ARB_GCALL    = 8'h78;
   localparam logic [7:0] SC_SR_DATA_ACK     = 8'h80;
   localparam logic [7:0] SC_SR_DATA_NACK    = 8'h88;
   localparam logic [7:0] SC_SR_GC_DATA_ACK  = 8'h90;
   localparam logic [7:0] SC_SR_GC_DATA_NACK = 8'h98;
   localparam logic [7:0] SC_SR_STOP         = 8'ha0;

   localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;

   // controller to datapath
   typedef struct packed {
      logic idle;
      logic accept;
      logic exec;
      logic fetch_step;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fetch_start;
      logic fetch_last;
      logic out_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/i2c_master_tx_slave_rx_sequencer.sv -----
// Top level of the two-wire bus master-transmit / slave-receive sequencer.
// Depends on i2c_seq_pkg, i2c_seq_ctrl, i2c_seq_dp and assert_macros.svh.
//
// Usage:
//   req_* carries one request (bus status event, transmit byte load, send
//   start or packet fetch); it transfers when req_valid is high and req_stall
//   is low. rsp_* carries results; a result transfers when rsp_valid is high
//   and rsp_stall is low. csr_retry_limit is written through csr_valid /
//   csr_ready, which is always ready; write it only while the block is idle.
//   Timing: a request is taken in the idle state and worked on in the next
//   cycle; no new request is taken until its work cycle ends. Its result is
//   registered and shows in the cycle after the work cycle. A fetch of a
//   completed packet first enters its streaming state; its bytes then follow
//   one per cycle while the result register is not stalled, through the single
//   read port of the receive buffer, and the next request is taken in the cycle
//   after the last byte is issued.
//   A waiting result does not block taking the next request; the work cycle
//   holds while the result register is full and stalled.
//   Reset clears all sequencing state and sets the retry limit to 3; the
//   byte buffers need no clearing pass and are usable at once.
module i2c_master_tx_slave_rx_sequencer
   import i2c_seq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_retry_limit,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_status_code,
   input  logic [7:0]        req_bus_data,
   input  logic [3:0]        req_tx_index,
   input  logic [7:0]        req_tx_byte,
   input  logic [6:0]        req_dest_address,
   input  logic [CNT_W-1:0]  req_send_length,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_bus_command,
   output logic              rsp_data_out_valid,
   output logic [7:0]        rsp_data_out,
   output logic              rsp_send_accepted,
   output logic              rsp_rx_valid,
   output logic [7:0]        rsp_rx_byte,
   output logic              rsp_rx_last,
   output logic [CNT_W-1:0]  rsp_rx_count,
   output logic              rsp_rx_general_call,
   output logic              rsp_rx_overflow,
   output logic              rsp_sending_busy,
   output logic              rsp_send_done
);

`include "assert_macros.svh"

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;
   assign req_stall = !ctrl_cmd.idle;

   i2c_seq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status_i  (dp_status),
      .cmd_o     (ctrl_cmd)
   );

   i2c_seq_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd_i               (ctrl_cmd),
      .status_o            (dp_status),
      .cfg_we              (csr_valid && csr_ready),
      .cfg_retry_limit     (csr_retry_limit),
      .req_func            (req_func),
      .req_status_code     (req_status_code),
      .req_bus_data        (req_bus_data),
      .req_tx_index        (req_tx_index),
      .req_tx_byte         (req_tx_byte),
      .req_dest_address    (req_dest_address),
      .req_send_length     (req_send_length),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_bus_command     (rsp_bus_command),
      .rsp_data_out_valid  (rsp_data_out_valid),
      .rsp_data_out        (rsp_data_out),
      .rsp_send_accepted   (rsp_send_accepted),
      .rsp_rx_valid        (rsp_rx_valid),
      .rsp_rx_byte         (rsp_rx_byte),
      .rsp_rx_last         (rsp_rx_last),
      .rsp_rx_count        (rsp_rx_count),
      .rsp_rx_general_call (rsp_rx_general_call),
      .rsp_rx_overflow     (rsp_rx_overflow),
      .rsp_sending_busy    (rsp_sending_busy),
      .rsp_send_done       (rsp_send_done)
   );

   // a taken request keeps the input side busy for its work cycle
   `ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   // a packet streams without gaps until its last byte
   `ASSERT_NEXT(a_fetch_stream, clock, reset,
                rsp_valid && !rsp_stall && rsp_rx_valid && !rsp_rx_last,
                rsp_valid && rsp_rx_valid)
   // a finished send always ends with a stop and no send in progress
   `ASSERT_IMPLY(a_done_stops, clock, reset, rsp_valid && rsp_send_done,
                 rsp_bus_command == CMD_STOP && !rsp_sending_busy)
   // packet items never carry bus bytes
   `ASSERT_IMPLY(a_rx_no_drive, clock, reset, rsp_valid && rsp_rx_valid,
                 !rsp_data_out_valid && rsp_bus_command == CMD_NONE)

endmodule

// ----- hw/rtl/i2c_seq_ctrl.sv -----
// Controller state machine of the two-wire bus sequencer.
// Depends on i2c_seq_pkg; steers i2c_seq_dp through command and status structs.
module i2c_seq_ctrl
   import i2c_seq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status_i,
   output ctrl_cmd_type  cmd_o
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_FETCH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // decode commands and next state
   always_comb begin
      state_in         = state_ff;
      cmd_o.idle       = 1'b0;
      cmd_o.accept     = 1'b0;
      cmd_o.exec       = 1'b0;
      cmd_o.fetch_step = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd_o.idle = 1'b1;
            if (req_valid) begin
               cmd_o.accept = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status_i.fetch_start) begin
               state_in = S_FETCH;
            end else if (status_i.out_free) begin
               cmd_o.exec = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_FETCH: begin
            if (status_i.out_free) begin
               cmd_o.fetch_step = 1'b1;
               if (status_i.fetch_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/i2c_seq_dp.sv -----
// Datapath of the two-wire bus sequencer: item latch, transmit and receive
// buffers, sequencing state and the result register. Depends on i2c_seq_pkg.
module i2c_seq_dp
   import i2c_seq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd_i,
   output dp_status_type     status_o,
   // configuration
   input  logic              cfg_we,
   input  logic [3:0]        cfg_retry_limit,
   // request item
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_status_code,
   input  logic [7:0]        req_bus_data,
   input  logic [3:0]        req_tx_index,
   input  logic [7:0]        req_tx_byte,
   input  logic [6:0]        req_dest_address,
   input  logic [CNT_W-1:0]  req_send_length,
   // result item
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [1:0]        rsp_bus_command,
   output logic              rsp_data_out_valid,
   output logic [7:0]        rsp_data_out,
   output logic              rsp_send_accepted,
   output logic              rsp_rx_valid,
   output logic [7:0]        rsp_rx_byte,
   output logic              rsp_rx_last,
   output logic [CNT_W-1:0]  rsp_rx_count,
   output logic              rsp_rx_general_call,
   output logic              rsp_rx_overflow,
   output logic              rsp_sending_busy,
   output logic              rsp_send_done
);

   typedef struct packed {
      logic [1:0]       bus_command;
      logic             data_out_valid;
      logic [7:0]       data_out;
      logic             send_accepted;
      logic             rx_valid;
      logic [7:0]       rx_byte;
      logic             rx_last;
      logic [CNT_W-1:0] rx_count;
      logic             rx_general_call;
      logic             rx_overflow;
      logic             sending_busy;
      logic             send_done;
   } result_type;

   // latched item
   logic [1:0]       func_ff;
   logic [7:0]       status_ff;
   logic [7:0]       bus_data_ff;
   logic [3:0]       tx_index_ff;
   logic [7:0]       tx_byte_ff;
   logic [6:0]       dest_ff;
   logic [CNT_W-1:0] send_len_ff;

   // buffers
   logic [7:0]       tx_mem [BUF_DEPTH];
   logic [7:0]       rx_mem [BUF_DEPTH];
   logic [7:0]       tx_rd_ff;
   logic [7:0]       rx_rd_ff;
   logic [BUF_AW-1:0] tx_raddr;
   logic [BUF_AW-1:0] rx_raddr;
   logic             tx_we;
   logic             rx_we;
   logic [BUF_AW-1:0] rx_waddr;

   // sequencing state
   logic [3:0]       retry_limit_ff;
   logic             sending_ff, sending_in;
   logic             receiving_ff, receiving_in;
   logic [3:0]       retry_ff, retry_in;
   logic [CNT_W-1:0] tx_len_ff, tx_len_in;
   logic [CNT_W-1:0] tx_pos_ff, tx_pos_in;
   logic [6:0]       tx_target_ff, tx_target_in;
   logic [CNT_W-1:0] rx_fill_ff, rx_fill_in;
   logic             rx_done_ff, rx_done_in;
   logic             rx_ovf_ff, rx_ovf_in;
   logic             rx_gc_ff, rx_gc_in;
   logic [CNT_W-1:0] fetch_k_ff, fetch_k_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff;
   result_type       exec_res;
   result_type       fetch_res;

   // helpers
   logic [7:0]       status_class;
   logic [CNT_W-1:0] fill_base;
   logic             ovf_base;
   logic             gc_base;
   logic [CNT_W-1:0] fetch_items;
   logic [CNT_W-1:0] fetch_k_next;
   logic             exec_done;
   logic             rx_take;
   logic             rx_take_gc;

   // buffer base when a byte arrives: a completed packet is discarded first
   assign fill_base = rx_done_ff ? '0 : rx_fill_ff;
   assign ovf_base  = rx_done_ff ? 1'b0 : rx_ovf_ff;
   assign gc_base   = rx_done_ff ? 1'b0 : rx_gc_ff;

   assign status_class = status_ff & SC_MASK;
   assign fetch_items  = (rx_fill_ff == '0) ? CNT_W'(1) : rx_fill_ff;
   assign fetch_k_next = fetch_k_ff + CNT_W'(1);

   // status to controller
   assign status_o.out_free    = !out_valid_ff || !rsp_stall;
   assign status_o.fetch_start = (func_ff == FUNC_FETCH) && rx_done_ff;
   assign status_o.fetch_last  = (fetch_k_next == fetch_items);

   // buffer read addresses: address-ack uses entry zero
   assign tx_raddr = ((req_status_code & SC_MASK) == SC_MT_SLA_ACK) ?
                     '0 : tx_pos_ff[BUF_AW-1:0];
   assign rx_raddr = cmd_i.fetch_step ? fetch_k_next[BUF_AW-1:0] : '0;

   // process one item
   always_comb begin
      sending_in   = sending_ff;
      receiving_in = receiving_ff;
      retry_in     = retry_ff;
      tx_len_in    = tx_len_ff;
      tx_pos_in    = tx_pos_ff;
      tx_target_in = tx_target_ff;
      rx_fill_in   = rx_fill_ff;
      rx_done_in   = rx_done_ff;
      rx_ovf_in    = rx_ovf_ff;
      rx_gc_in     = rx_gc_ff;
      tx_we        = 1'b0;
      rx_we        = 1'b0;
      rx_waddr     = fill_base[BUF_AW-1:0];
      rx_take      = 1'b0;
      rx_take_gc   = 1'b0;
      exec_done    = 1'b0;
      exec_res     = '0;
      exec_res.bus_command = CMD_NONE;

      if (cmd_i.exec) begin
         case (func_ff)
            FUNC_EVENT: begin
               exec_res.bus_command = CMD_RELEASE;
               case (status_class) inside
                  SC_SR_SLA_ACK, SC_SR_ARB_SLA, SC_SR_GCALL, SC_SR_ARB_GCALL: begin
                     receiving_in = 1'b1;
                  end
                  SC_SR_DATA_ACK, SC_SR_DATA_NACK: begin
                     rx_take = 1'b1;
                  end
                  SC_SR_GC_DATA_ACK, SC_SR_GC_DATA_NACK: begin
                     rx_take    = 1'b1;
                     rx_take_gc = 1'b1;
                  end
                  SC_SR_STOP: begin
                     if (receiving_ff) begin
                        rx_done_in   = 1'b1;
                        receiving_in = 1'b0;
                     end
                     exec_res.bus_command = sending_ff ? CMD_START : CMD_RELEASE;
                  end
                  SC_START, SC_REP_START: begin
                     if (sending_ff) begin
                        exec_res.data_out_valid = 1'b1;
                        exec_res.data_out       = {tx_target_ff, 1'b0};
                        if (status_class == SC_START) begin
                           retry_in = '0;
                        end
                     end else begin
                        exec_res.bus_command = CMD_STOP;
                     end
                  end
                  SC_MT_SLA_ACK: begin
                     if (sending_ff && tx_len_ff != '0) begin
                        exec_res.data_out_valid = 1'b1;
                        exec_res.data_out       = tx_rd_ff;
                        tx_pos_in               = CNT_W'(1);
                        retry_in                = '0;
                     end else begin
                        exec_res.bus_command = CMD_STOP;
                     end
                  end
                  SC_MT_SLA_NACK: begin
                     if (retry_ff < retry_limit_ff) begin
                        exec_res.bus_command = CMD_START;
                        retry_in             = retry_ff + 4'd1;
                     end else begin
                        exec_res.bus_command = CMD_STOP;
                        sending_in           = 1'b0;
                     end
                  end
                  SC_MT_DATA_ACK: begin
                     if (sending_ff) begin
                        if (tx_pos_ff < tx_len_ff && tx_pos_ff < CNT_W'(BUF_DEPTH)) begin
                           exec_res.data_out_valid = 1'b1;
                           exec_res.data_out       = tx_rd_ff;
                           tx_pos_in               = tx_pos_ff + CNT_W'(1);
                        end else begin
                           exec_res.bus_command = CMD_STOP;
                           sending_in           = 1'b0;
                           exec_done            = 1'b1;
                        end
                     end else begin
                        exec_res.bus_command = CMD_STOP;
                     end
                  end
                  SC_MT_DATA_NACK: begin
                     exec_res.bus_command = CMD_STOP;
                     sending_in           = 1'b0;
                  end
                  SC_ARB_LOST: begin
                     exec_res.bus_command = CMD_START;
                  end
                  default: begin
                     exec_res.bus_command = CMD_RELEASE;
                  end
               endcase
            end
            FUNC_LOAD: begin
               if (!sending_ff && ({1'b0, tx_index_ff} < CNT_W'(BUF_DEPTH))) begin
                  tx_we = 1'b1;
               end
            end
            FUNC_SEND: begin
               if (!sending_ff && send_len_ff != '0 &&
                   send_len_ff <= CNT_W'(BUF_DEPTH)) begin
                  tx_len_in              = send_len_ff;
                  tx_target_in           = dest_ff;
                  tx_pos_in              = '0;
                  sending_in             = 1'b1;
                  exec_res.send_accepted = 1'b1;
                  if (!receiving_ff) begin
                     exec_res.bus_command = CMD_START;
                  end
               end
            end
            default: begin
               // fetch with nothing complete: empty answer
            end
         endcase

         // store a received byte, dropping it when the buffer is full
         if (rx_take) begin
            receiving_in = 1'b1;
            rx_done_in   = 1'b0;
            rx_ovf_in    = ovf_base;
            rx_gc_in     = gc_base | rx_take_gc;
            if (fill_base < CNT_W'(BUF_DEPTH)) begin
               rx_we      = 1'b1;
               rx_fill_in = fill_base + CNT_W'(1);
            end else begin
               rx_fill_in = fill_base;
               rx_ovf_in  = 1'b1;
            end
         end
      end

      // drop the packet after its last item goes out
      if (cmd_i.fetch_step && status_o.fetch_last) begin
         rx_fill_in = '0;
         rx_done_in = 1'b0;
         rx_ovf_in  = 1'b0;
         rx_gc_in   = 1'b0;
      end

      exec_res.sending_busy = sending_in;
      exec_res.send_done    = exec_done;
   end

   // one item of a fetched packet
   always_comb begin
      fetch_res                 = '0;
      fetch_res.bus_command     = CMD_NONE;
      fetch_res.rx_valid        = 1'b1;
      fetch_res.rx_byte         = (rx_fill_ff != '0) ? rx_rd_ff : 8'd0;
      fetch_res.rx_last         = status_o.fetch_last;
      fetch_res.rx_count        = rx_fill_ff;
      fetch_res.rx_general_call = rx_gc_ff;
      fetch_res.rx_overflow     = rx_ovf_ff;
      fetch_res.sending_busy    = sending_ff;
   end

   // advance fetch position
   always_comb begin
      fetch_k_in = fetch_k_ff;
      if (cmd_i.accept) begin
         fetch_k_in = '0;
      end else if (cmd_i.fetch_step) begin
         fetch_k_in = fetch_k_next;
      end
   end

   // hold the result until the receiver takes it
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd_i.exec || cmd_i.fetch_step) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control and sequencing state
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RESET;
         sending_ff     <= 1'b0;
         receiving_ff   <= 1'b0;
         retry_ff       <= '0;
         tx_len_ff      <= '0;
         tx_pos_ff      <= '0;
         tx_target_ff   <= '0;
         rx_fill_ff     <= '0;
         rx_done_ff     <= 1'b0;
         rx_ovf_ff      <= 1'b0;
         rx_gc_ff       <= 1'b0;
         fetch_k_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (cfg_we) begin
            retry_limit_ff <= cfg_retry_limit;
         end
         sending_ff   <= sending_in;
         receiving_ff <= receiving_in;
         retry_ff     <= retry_in;
         tx_len_ff    <= tx_len_in;
         tx_pos_ff    <= tx_pos_in;
         tx_target_ff <= tx_target_in;
         rx_fill_ff   <= rx_fill_in;
         rx_done_ff   <= rx_done_in;
         rx_ovf_ff    <= rx_ovf_in;
         rx_gc_ff     <= rx_gc_in;
         fetch_k_ff   <= fetch_k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // latch the item on a transfer
   always_ff @(posedge clock) begin
      if (cmd_i.accept) begin
         func_ff     <= req_func;
         status_ff   <= req_status_code;
         bus_data_ff <= req_bus_data;
         tx_index_ff <= req_tx_index;
         tx_byte_ff  <= req_tx_byte;
         dest_ff     <= req_dest_address;
         send_len_ff <= req_send_length;
      end
   end

   // transmit buffer
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_index_ff[BUF_AW-1:0]] <= tx_byte_ff;
      end
      if (cmd_i.accept) begin
         tx_rd_ff <= tx_mem[tx_raddr];
      end
   end

   // receive buffer
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_waddr] <= bus_data_ff;
      end
      if (cmd_i.accept || cmd_i.fetch_step) begin
         rx_rd_ff <= rx_mem[rx_raddr];
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd_i.exec) begin
         out_ff <= exec_res;
      end else if (cmd_i.fetch_step) begin
         out_ff <= fetch_res;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_bus_command     = out_ff.bus_command;
   assign rsp_data_out_valid  = out_ff.data_out_valid;
   assign rsp_data_out        = out_ff.data_out;
   assign rsp_send_accepted   = out_ff.send_accepted;
   assign rsp_rx_valid        = out_ff.rx_valid;
   assign rsp_rx_byte         = out_ff.rx_byte;
   assign rsp_rx_last         = out_ff.rx_last;
   assign rsp_rx_count        = out_ff.rx_count;
   assign rsp_rx_general_call = out_ff.rx_general_call;
   assign rsp_rx_overflow     = out_ff.rx_overflow;
   assign rsp_sending_busy    = out_ff.sending_busy;
   assign rsp_send_done       = out_ff.send_done;

endmodule

// ----- verif/i2c_seq_checker.sv -----
// Result checker for the two-wire bus sequencer: watches the request, result and
// CSR channels, predicts every result transfer and compares it field by field.
// Depends on i2c_seq_pkg for the function, command and status codes.
module i2c_seq_checker
   import i2c_seq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [3:0]        csr_retry_limit,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_status_code,
   input  logic [7:0]        req_bus_data,
   input  logic [3:0]        req_tx_index,
   input  logic [7:0]        req_tx_byte,
   input  logic [6:0]        req_dest_address,
   input  logic [CNT_W-1:0]  req_send_length,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [1:0]        rsp_bus_command,
   input  logic              rsp_data_out_valid,
   input  logic [7:0]        rsp_data_out,
   input  logic              rsp_send_accepted,
   input  logic              rsp_rx_valid,
   input  logic [7:0]        rsp_rx_byte,
   input  logic              rsp_rx_last,
   input  logic [CNT_W-1:0]  rsp_rx_count,
   input  logic              rsp_rx_general_call,
   input  logic              rsp_rx_overflow,
   input  logic              rsp_sending_busy,
   input  logic              rsp_send_done,
   output int unsigned       mismatches,
   output int unsigned       outstanding
);

   typedef struct packed {
      logic [1:0]       bus_command;
      logic             data_out_valid;
      logic [7:0]       data_out;
      logic             send_accepted;
      logic             rx_valid;
      logic [7:0]       rx_byte;
      logic             rx_last;
      logic [CNT_W-1:0] rx_count;
      logic             rx_general_call;
      logic             rx_overflow;
      logic             sending_busy;
      logic             send_done;
   } seq_result_type;

   // results still owed by the block, oldest first
   seq_result_type   rsp_due[$];

   // mirror of the sequencer state
   logic [3:0]       retry_lim;
   logic             sending;
   logic             receiving;
   logic [3:0]       retry_cnt;
   logic [7:0]       tx_mem [BUF_DEPTH];
   logic [CNT_W-1:0] tx_len;
   logic [CNT_W-1:0] tx_pos;
   logic [6:0]       tx_dest;
   logic [7:0]       rx_mem [BUF_DEPTH];
   logic [CNT_W-1:0] rx_fill;
   logic             rx_done;
   logic             rx_ovf;
   logic             rx_gc;

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("result %s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // apply one accepted request to the mirror and queue the results it causes
   task automatic advance_sequencer(input logic [1:0] func, input logic [7:0] status,
                                    input logic [7:0] data, input logic [3:0] idx,
                                    input logic [7:0] txb, input logic [6:0] dest,
                                    input logic [CNT_W-1:0] len);
      seq_result_type   r;
      logic             take_byte;
      logic             take_gc;
      logic [CNT_W-1:0] items;
      r = '0;
      r.bus_command = CMD_NONE;
      take_byte = 1'b0;
      take_gc = 1'b0;
      case (func)
         FUNC_EVENT: begin
            r.bus_command = CMD_RELEASE;
            case (status & SC_MASK)
               SC_SR_SLA_ACK, SC_SR_ARB_SLA, SC_SR_GCALL, SC_SR_ARB_GCALL:
                  receiving = 1'b1;
               SC_SR_DATA_ACK, SC_SR_DATA_NACK:
                  take_byte = 1'b1;
               SC_SR_GC_DATA_ACK, SC_SR_GC_DATA_NACK: begin
                  take_byte = 1'b1;
                  take_gc = 1'b1;
               end
               SC_SR_STOP: begin
                  if (receiving) begin
                     rx_done = 1'b1;
                     receiving = 1'b0;
                  end
                  r.bus_command = sending ? CMD_START : CMD_RELEASE;
               end
               SC_START, SC_REP_START: begin
                  if (sending) begin
                     r.data_out_valid = 1'b1;
                     r.data_out = {tx_dest, 1'b0};
                     if ((status & SC_MASK) == SC_START) retry_cnt = '0;
                  end else begin
                     r.bus_command = CMD_STOP;
                  end
               end
               SC_MT_SLA_ACK: begin
                  if (sending && tx_len != '0) begin
                     r.data_out_valid = 1'b1;
                     r.data_out = tx_mem[0];
                     tx_pos = CNT_W'(1);
                     retry_cnt = '0;
                  end else begin
                     r.bus_command = CMD_STOP;
                  end
               end
               SC_MT_SLA_NACK: begin
                  if (retry_cnt < retry_lim) begin
                     r.bus_command = CMD_START;
                     retry_cnt = retry_cnt + 4'd1;
                  end else begin
                     r.bus_command = CMD_STOP;
                     sending = 1'b0;
                  end
               end
               SC_MT_DATA_ACK: begin
                  if (!sending) begin
                     r.bus_command = CMD_STOP;
                  end else if (tx_pos < tx_len) begin
                     r.data_out_valid = 1'b1;
                     r.data_out = tx_mem[tx_pos[3:0]];
                     tx_pos = tx_pos + 1'b1;
                  end else begin
                     r.bus_command = CMD_STOP;
                     sending = 1'b0;
                     r.send_done = 1'b1;
                  end
               end
               SC_MT_DATA_NACK: begin
                  r.bus_command = CMD_STOP;
                  sending = 1'b0;
               end
               SC_ARB_LOST:
                  r.bus_command = CMD_START;
               default: ;
            endcase
            // store a received byte; a new byte discards a completed packet
            if (take_byte) begin
               if (rx_done) begin
                  rx_done = 1'b0;
                  rx_ovf = 1'b0;
                  rx_gc = 1'b0;
                  rx_fill = '0;
               end
               receiving = 1'b1;
               if (take_gc) rx_gc = 1'b1;
               if (rx_fill < BUF_DEPTH) begin
                  rx_mem[rx_fill[3:0]] = data;
                  rx_fill = rx_fill + 1'b1;
               end else begin
                  rx_ovf = 1'b1;
               end
            end
            r.sending_busy = sending;
            rsp_due.push_back(r);
         end
         FUNC_LOAD: begin
            if (!sending) tx_mem[idx] = txb;
            r.sending_busy = sending;
            rsp_due.push_back(r);
         end
         FUNC_SEND: begin
            if (!sending && len != '0 && len <= BUF_DEPTH) begin
               tx_len = len;
               tx_dest = dest;
               tx_pos = '0;
               sending = 1'b1;
               r.send_accepted = 1'b1;
               if (!receiving) r.bus_command = CMD_START;
            end
            r.sending_busy = sending;
            rsp_due.push_back(r);
         end
         default: begin
            // fetch: one empty answer, or the completed packet byte by byte
            r.sending_busy = sending;
            if (!rx_done) begin
               rsp_due.push_back(r);
            end else begin
               items = (rx_fill != '0) ? rx_fill : CNT_W'(1);
               r.rx_valid = 1'b1;
               r.rx_count = rx_fill;
               r.rx_general_call = rx_gc;
               r.rx_overflow = rx_ovf;
               for (int k = 0; k < items; k++) begin
                  r.rx_byte = (rx_fill != '0) ? rx_mem[k] : 8'h00;
                  r.rx_last = (k + 1 == items);
                  rsp_due.push_back(r);
               end
               rx_fill = '0;
               rx_done = 1'b0;
               rx_ovf = 1'b0;
               rx_gc = 1'b0;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      seq_result_type want;
      if (reset) begin
         rsp_due.delete();
         retry_lim = RETRY_LIMIT_RESET;
         sending = 1'b0;
         receiving = 1'b0;
         retry_cnt = '0;
         tx_len = '0;
         tx_pos = '0;
         tx_dest = '0;
         rx_fill = '0;
         rx_done = 1'b0;
         rx_ovf = 1'b0;
         rx_gc = 1'b0;
         mismatches = 0;
      end else begin
         // check a result transfer against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               $error("result transfer with no result expected (bus_command %0d)",
                      rsp_bus_command);
               mismatches++;
            end else begin
               want = rsp_due.pop_front();
               compare_field("bus_command", want.bus_command, rsp_bus_command);
               compare_field("data_out_valid", want.data_out_valid, rsp_data_out_valid);
               compare_field("data_out", want.data_out, rsp_data_out);
               compare_field("send_accepted", want.send_accepted, rsp_send_accepted);
               compare_field("rx_valid", want.rx_valid, rsp_rx_valid);
               compare_field("rx_byte", want.rx_byte, rsp_rx_byte);
               compare_field("rx_last", want.rx_last, rsp_rx_last);
               compare_field("rx_count", want.rx_count, rsp_rx_count);
               compare_field("rx_general_call", want.rx_general_call,
                             rsp_rx_general_call);
               compare_field("rx_overflow", want.rx_overflow, rsp_rx_overflow);
               compare_field("sending_busy", want.sending_busy, rsp_sending_busy);
               compare_field("send_done", want.send_done, rsp_send_done);
            end
         end
         if (csr_valid && csr_ready) retry_lim = csr_retry_limit;
         if (req_valid && !req_stall)
            advance_sequencer(req_func, req_status_code, req_bus_data, req_tx_index,
                              req_tx_byte, req_dest_address, req_send_length);
      end
      outstanding = rsp_due.size();
   end

endmodule

// ----- verif/i2c_master_tx_slave_rx_sequencer_tb.sv -----
// Testbench top for the two-wire bus sequencer: drives requests, CSR writes and
// result back-pressure, and prints the verdict from the checker's mismatch count.
// Depends on i2c_seq_pkg, i2c_master_tx_slave_rx_sequencer and i2c_seq_checker.
module i2c_master_tx_slave_rx_sequencer_tb;
   import i2c_seq_pkg::*;

   localparam int TOTAL_ITEMS = 430;
   localparam int NUM_PHASES  = 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;

   logic              clock;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [3:0]        csr_retry_limit;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_func;
   logic [7:0]        req_status_code;
   logic [7:0]        req_bus_data;
   logic [3:0]        req_tx_index;
   logic [7:0]        req_tx_byte;
   logic [6:0]        req_dest_address;
   logic [CNT_W-1:0]  req_send_length;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_bus_command;
   logic              rsp_data_out_valid;
   logic [7:0]        rsp_data_out;
   logic              rsp_send_accepted;
   logic              rsp_rx_valid;
   logic [7:0]        rsp_rx_byte;
   logic              rsp_rx_last;
   logic [CNT_W-1:0]  rsp_rx_count;
   logic              rsp_rx_general_call;
   logic              rsp_rx_overflow;
   logic              rsp_sending_busy;
   logic              rsp_send_done;
   int unsigned       mismatches;
   int unsigned       outstanding;

   int unsigned       items_sent;
   int unsigned       burst_left;
   int unsigned       cycle_count;
   logic              start_hold;

   i2c_master_tx_slave_rx_sequencer dut (.*);
   i2c_seq_checker chk (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result back-pressure: random stall rate per stretch, one long hold-off
   initial begin : rsp_sink
      int unsigned stall_pct;
      int unsigned hold_left;
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 80;
         endcase
         repeat ($urandom_range(20, 120)) begin
            @(posedge clock);
            if (start_hold) begin
               start_hold = 1'b0;
               hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
               hold_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            end
         end
      end
   end

   // offer one request and hold it until the transfer; idle between bursts
   task automatic push_item(input logic [1:0] func, input logic [7:0] status,
                            input logic [7:0] data, input logic [3:0] idx,
                            input logic [7:0] txb, input logic [6:0] dest,
                            input logic [CNT_W-1:0] len);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_status_code <= status;
      req_bus_data <= data;
      req_tx_index <= idx;
      req_tx_byte <= txb;
      req_dest_address <= dest;
      req_send_length <= len;
      do @(posedge clock); while (req_stall);
      burst_left--;
      items_sent++;
   endtask

   // bus status event; the ignored low status bits and unused fields are random
   task automatic do_event(input logic [7:0] code);
      logic [63:0] rnd;
      rnd = {$urandom, $urandom};
      push_item(FUNC_EVENT, code | {5'd0, rnd[2:0]}, rnd[10:3], rnd[14:11], rnd[22:15],
                rnd[29:23], rnd[34:30]);
   endtask

   task automatic do_load(input logic [3:0] idx, input logic [7:0] val);
      logic [63:0] rnd;
      rnd = {$urandom, $urandom};
      push_item(FUNC_LOAD, rnd[7:0], rnd[15:8], idx, val, rnd[22:16], rnd[27:23]);
   endtask

   task automatic do_send(input logic [6:0] dest, input logic [CNT_W-1:0] len);
      logic [63:0] rnd;
      rnd = {$urandom, $urandom};
      push_item(FUNC_SEND, rnd[7:0], rnd[15:8], rnd[19:16], rnd[27:20], dest, len);
   endtask

   task automatic do_fetch();
      logic [63:0] rnd;
      rnd = {$urandom, $urandom};
      push_item(FUNC_FETCH, rnd[7:0], rnd[15:8], rnd[19:16], rnd[27:20], rnd[34:28],
                rnd[39:35]);
   endtask

   // master transmit: request, start, address retries, address ack, data bytes
   task automatic master_send_sequence();
      logic [CNT_W-1:0] len;
      logic [6:0]       dest;
      int unsigned      nacks;
      int unsigned      acks;
      logic             early_nack;
      len = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(1, BUF_DEPTH))
                                        : CNT_W'($urandom_range(1, 5));
      dest = 7'($urandom_range(0, 127));
      // sometimes request the send in the middle of a slave receive
      if ($urandom_range(0, 4) == 0) begin
         do_event(SC_SR_SLA_ACK);
         do_send(dest, len);
         repeat ($urandom_range(0, 3)) do_event(SC_SR_DATA_ACK);
         do_event(SC_SR_STOP);
      end else begin
         do_send(dest, len);
      end
      do_event(SC_START);
      nacks = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 17) : $urandom_range(0, 2);
      repeat (nacks) begin
         do_event(SC_MT_SLA_NACK);
         do_event(SC_REP_START);
      end
      do_event(SC_MT_SLA_ACK);
      early_nack = ($urandom_range(0, 5) == 0);
      acks = early_nack ? $urandom_range(0, len - 1) : len;
      repeat (acks) do_event(SC_MT_DATA_ACK);
      if (early_nack) do_event(SC_MT_DATA_NACK);
   endtask

   // slave receive: addressed or general call, data bytes, stop, usually a fetch
   task automatic slave_receive_sequence();
      int unsigned n;
      logic        gc;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 6);
      gc = $urandom_range(0, 1);
      if (gc) do_event($urandom_range(0, 1) ? SC_SR_GCALL : SC_SR_ARB_GCALL);
      else do_event($urandom_range(0, 1) ? SC_SR_SLA_ACK : SC_SR_ARB_SLA);
      repeat (n) begin
         if (gc) do_event($urandom_range(0, 1) ? SC_SR_GC_DATA_ACK : SC_SR_GC_DATA_NACK);
         else do_event($urandom_range(0, 1) ? SC_SR_DATA_ACK : SC_SR_DATA_NACK);
      end
      do_event(SC_SR_STOP);
      if ($urandom_range(0, 9) < 7) do_fetch();
   endtask

   task automatic random_transaction();
      int unsigned pick;
      logic [63:0] rnd;
      pick = $urandom_range(0, 99);
      rnd = {$urandom, $urandom};
      if (pick < 35) master_send_sequence();
      else if (pick < 65) slave_receive_sequence();
      else if (pick < 75) repeat ($urandom_range(1, 3)) do_load(rnd[3:0], rnd[11:4]);
      else if (pick < 82) do_fetch();
      else if (pick < 88) do_send(rnd[6:0], rnd[11:7]);
      else push_item(rnd[1:0], rnd[9:2], rnd[17:10], rnd[21:18], rnd[29:22], rnd[36:30],
                     rnd[41:37]);
   endtask

   // drain all results, then write the retry limit while the block is idle
   task automatic write_retry_limit(input logic [3:0] val);
      req_valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_retry_limit <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [3:0] phase_limit [NUM_PHASES];
      phase_limit = '{4'd0, 4'd15, 4'd1, 4'd9, 4'd5};
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_retry_limit = '0;
      req_valid = 1'b0;
      req_func = FUNC_EVENT;
      req_status_code = '0;
      req_bus_data = '0;
      req_tx_index = '0;
      req_tx_byte = '0;
      req_dest_address = '0;
      req_send_length = '0;
      start_hold = 1'b0;
      items_sent = 0;
      burst_left = 0;
      cycle_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // fill the whole transmit store before any send can read it
      for (int i = 0; i < BUF_DEPTH; i++)
         do_load(i[3:0], (i == 0) ? 8'h00 : (i == BUF_DEPTH - 1) ? 8'hff
                                          : 8'($urandom_range(0, 255)));
      // fetch with no completed packet, unknown status, master event while idle
      do_fetch();
      do_event(8'hf8);
      do_event(SC_START);
      // complete a packet that carries no bytes, then fetch it
      do_event(SC_SR_ARB_GCALL);
      do_event(SC_SR_STOP);
      do_fetch();
      // refused sends on length, a full-length send, then load and send while busy
      do_send(7'h7f, 5'd0);
      do_send(7'h00, 5'd31);
      do_send(7'h7f, 5'd16);
      do_load(4'd0, 8'h5a);
      do_send(7'h11, 5'd1);
      // address out, then a data NACK ends the send
      do_event(SC_START);
      do_event(SC_MT_DATA_NACK);

      // random phases, each under its own retry limit
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_retry_limit(phase_limit[p]);
         if (p == 1) start_hold = 1'b1;
         while (items_sent < (p + 1) * TOTAL_ITEMS / NUM_PHASES) random_transaction();
      end

      // drain and let any stray result show up
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/i2c_seq_pkg.sv
hw/rtl/i2c_seq_ctrl.sv
hw/rtl/i2c_seq_dp.sv
hw/rtl/i2c_master_tx_slave_rx_sequencer.sv
verif/i2c_seq_checker.sv
verif/i2c_master_tx_slave_rx_sequencer_tb.sv
